### rtl/tsp_pkg.sv
// Shared types and constants for the tone sequence player.
package tsp_pkg;

    localparam int FREQ_W      = 16;
    localparam int DUR_W       = 16;
    localparam int SLOT_W      = 4;
    localparam int OP_W        = 2;
    localparam int LEN_W       = 5;
    localparam int GAP_W       = 16;
    localparam int ELAPSED_W   = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_NOTES_D = 16;

    localparam logic [LEN_W-1:0] TUNE_LEN_RST = LEN_W'(1);
    localparam logic [GAP_W-1:0] SIL_GAP_RST  = GAP_W'(40);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TUNE_LENGTH = 2'd0,
        CFG_REPEAT_EN   = 2'd1,
        CFG_REPEAT_GAP  = 2'd2,
        CFG_SILENCE_GAP = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

endpackage

### rtl/tsp_if.sv
// Request and result channel interfaces of the tone sequence player.
interface tsp_in_if import tsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] entry_index;
    logic [FREQ_W-1:0] entry_freq;
    logic [DUR_W-1:0]  entry_duration;

    modport source (output valid, operation, entry_index, entry_freq, entry_duration,
                    input ready);
    modport sink   (input valid, operation, entry_index, entry_freq, entry_duration,
                    output ready);
endinterface

interface tsp_out_if import tsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] tone_freq;
    logic              freq_changed;
    logic              tune_done;

    modport source (output valid, tone_freq, freq_changed, tune_done, input ready);
    modport sink   (input valid, tone_freq, freq_changed, tune_done, output ready);
endinterface

### rtl/tsp_note_ram.sv
// Note table: one write port, one registered read port.
module tsp_note_ram import tsp_pkg::*; #(
    parameter int MAX_NOTES = MAX_NOTES_D,
    localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IW-1:0]     i_waddr,
    input  logic [FREQ_W-1:0] i_wfreq,
    input  logic [DUR_W-1:0]  i_wdur,
    input  logic              i_re,
    input  logic [IW-1:0]     i_raddr,
    output logic [FREQ_W-1:0] o_rfreq,
    output logic [DUR_W-1:0]  o_rdur
);

    logic [FREQ_W+DUR_W-1:0] r_mem [MAX_NOTES];
    logic [FREQ_W+DUR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wfreq, i_wdur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rfreq = r_rdata[FREQ_W+DUR_W-1:DUR_W];
    assign o_rdur  = r_rdata[DUR_W-1:0];

endmodule

### rtl/tone_sequence_player.sv
// Tone sequence player: note table, millisecond walk and tone output.
//
// Usage: requests arrive on i_in (valid/ready). operation WRITE loads note
// entry_index with entry_freq/entry_duration, TICK advances the elapsed
// millisecond count and replays the tune position, RESTART clears elapsed.
// Every request gives exactly one result on o_out: tone_freq, freq_changed
// and tune_done. Non-tick requests return the last driven frequency with
// both flags clear. Registers are written on i_cfg_we (index i_cfg_idx); the user
// writes them only while no request is in flight, and the block does not enforce it.
// Sequence: WRITE, RESTART and the spare code go from the accept state to the
// final state, which loads the result register. A TICK walks the table between
// the two, reading table entries up to and including the current note (at most
// min(tune_length, MAX_NOTES), 0 for an empty tune); the note table has a
// single read port and the walk reads one entry per cycle. One request is in
// flight at a time, and the next is not taken before the result loads.
// Reset (synchronous, i_rst_n low) clears elapsed time, last frequency and
// restores register defaults; table contents are kept and undefined after
// power-up. A stalled receiver holds the result; the walk waits in its final
// state until the output register frees, and i_in stays low meanwhile.
module tone_sequence_player import tsp_pkg::*; #(
    parameter int MAX_NOTES = MAX_NOTES_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tsp_in_if.sink                i_in,
    tsp_out_if.source             o_out
);

    localparam int IW  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW  = $clog2(MAX_NOTES + 1);
    localparam int TW  = DUR_W + $clog2(MAX_NOTES);

    t_state                r_state, n_state;
    logic [ELAPSED_W-1:0]  r_elapsed;
    logic [FREQ_W-1:0]     r_last;
    logic [LEN_W-1:0]      r_tune_len;
    logic                  r_rep_en;
    logic [GAP_W-1:0]      r_rep_gap;
    logic [GAP_W-1:0]      r_sil_gap;
    logic [IW-1:0]         r_k;
    logic [TW-1:0]         r_total;
    logic                  r_tick;
    logic                  r_found;
    logic [FREQ_W-1:0]     r_drive;
    logic                  r_out_valid;
    logic [FREQ_W-1:0]     r_out_freq;
    logic                  r_out_changed;
    logic                  r_out_done;

    logic                  w_accept;
    logic                  w_out_free;
    logic [CW-1:0]         w_count;
    logic [ELAPSED_W-1:0]  w_elapsed_inc;
    logic                  w_slot_ok;
    logic                  w_ram_we;
    logic                  w_ram_re;
    logic [IW-1:0]         w_ram_raddr;
    logic [FREQ_W-1:0]     w_rd_freq;
    logic [DUR_W-1:0]      w_rd_dur;
    logic [TW-1:0]         w_sum;
    logic [TW-1:0]         w_rem;
    logic                  w_hit;
    logic                  w_last;
    logic [FREQ_W-1:0]     w_note_drive;
    logic [FREQ_W-1:0]     w_tick_freq;
    logic                  w_wrap;

    tsp_note_ram #(
        .MAX_NOTES (MAX_NOTES)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (IW'(32'(i_in.entry_index))),
        .i_wfreq (i_in.entry_freq),
        .i_wdur  (i_in.entry_duration),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rfreq (w_rd_freq),
        .o_rdur  (w_rd_dur)
    );

    assign w_accept      = i_in.valid && i_in.ready;
    assign w_out_free    = !r_out_valid || o_out.ready;
    assign w_count       = (32'(r_tune_len) > 32'(MAX_NOTES)) ? CW'(MAX_NOTES)
                                                              : CW'(r_tune_len);
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_slot_ok     = 32'(i_in.entry_index) < 32'(MAX_NOTES);

    // walk step on the entry read in the previous cycle
    assign w_sum        = r_total + TW'(w_rd_dur);
    assign w_hit        = 32'(w_sum) >= r_elapsed;
    assign w_rem        = w_sum - TW'(r_elapsed);
    assign w_last       = (32'(r_k) + 1) >= 32'(w_count);
    assign w_note_drive = (w_rd_dur != '0 && w_rem > TW'(r_sil_gap)) ? w_rd_freq : '0;

    assign w_tick_freq  = r_found ? r_drive : '0;
    assign w_wrap       = !r_found && r_rep_en
                          && (r_elapsed > (32'(r_total) + 32'(r_rep_gap)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (t_op'(i_in.operation) == OP_TICK && w_count != '0) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_WALK: begin
                if (w_hit || w_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready  = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                w_ram_we   = i_in.valid && t_op'(i_in.operation) == OP_WRITE && w_slot_ok;
                w_ram_re   = i_in.valid && t_op'(i_in.operation) == OP_TICK;
            end
            S_WALK: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = r_k + 1'b1;
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_last      <= '0;
            r_tune_len  <= TUNE_LEN_RST;
            r_rep_en    <= 1'b0;
            r_rep_gap   <= '0;
            r_sil_gap   <= SIL_GAP_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_TUNE_LENGTH: r_tune_len <= i_cfg_data[LEN_W-1:0];
                    CFG_REPEAT_EN:   r_rep_en   <= i_cfg_data[0];
                    CFG_REPEAT_GAP:  r_rep_gap  <= i_cfg_data[GAP_W-1:0];
                    CFG_SILENCE_GAP: r_sil_gap  <= i_cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end

            // load from the final state, else hold until the receiver takes it
            r_out_valid <= (r_state == S_FIN && w_out_free) || (r_out_valid && !o_out.ready);

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_tick <= t_op'(i_in.operation) == OP_TICK;
                        if (t_op'(i_in.operation) == OP_TICK) begin
                            r_elapsed <= w_elapsed_inc;
                        end else if (t_op'(i_in.operation) == OP_RESTART) begin
                            r_elapsed <= '0;
                        end
                        r_k     <= '0;
                        r_total <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_WALK: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_drive <= w_note_drive;
                    end else begin
                        r_total <= w_sum;
                        r_k     <= r_k + 1'b1;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        if (r_tick) begin
                            r_out_freq    <= w_tick_freq;
                            r_out_changed <= w_tick_freq != r_last;
                            r_out_done    <= !r_found;
                            r_last        <= w_tick_freq;
                            if (w_wrap) begin
                                r_elapsed <= '0;
                            end
                        end else begin
                            r_out_freq    <= r_last;
                            r_out_changed <= 1'b0;
                            r_out_done    <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.tone_freq    = r_out_freq;
    assign o_out.freq_changed = r_out_changed;
    assign o_out.tune_done    = r_out_done;

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> (32'(r_k) < 32'(w_count)))
        else $error("walk index beyond tune length");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted request did not start work");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result loaded outside final state");

    a_done_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_freq == '0)
        else $error("tone driven past end of tune");

endmodule

### bench/tone_sequence_player_test.sv
// Self-checking testbench for the tone sequence player: directed and random requests.
module tone_sequence_player_test;
    import tsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // operation code the block has no use for; it must still answer
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } tone_req_t;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_freq;
        logic              freq_changed;
        logic              tune_done;
    } tone_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tsp_in_if  req_if ();
    tsp_out_if tone_if ();

    tone_sequence_player i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (tone_if)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [FREQ_W-1:0]    note_freq [MAX_NOTES_D];
    logic [DUR_W-1:0]     note_ms   [MAX_NOTES_D];
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [FREQ_W-1:0]    last_tone;
    logic [LEN_W-1:0]     cfg_len;
    logic                 cfg_repeat;
    logic [GAP_W-1:0]     cfg_repeat_gap;
    logic [GAP_W-1:0]     cfg_silence;

    tone_t tone_expect_q [$];
    int    fail_count    = 0;
    int    send_idle_pct = 0;
    int    stall_pct     = 0;
    int    dur_cap       = 4;
    int    hold_trig     = 0;
    int    hold_seen     = 0;
    int    hold_left     = 0;

    function automatic tone_t play_request(tone_req_t r);
        tone_t             res;
        longint unsigned   t;
        longint unsigned   end_ms;
        int                n;
        bit                found;
        logic [FREQ_W-1:0] drive;
        res = '{tone_freq: last_tone, freq_changed: 1'b0, tune_done: 1'b0};
        if (r.op != OP_TICK) begin
            if (r.op == OP_WRITE) begin
                note_freq[r.slot] = r.freq;
                note_ms[r.slot]   = r.dur;
            end else if (r.op == OP_RESTART) begin
                elapsed_ms = '0;
            end
            return res;
        end
        if (elapsed_ms != '1)
            elapsed_ms++;
        t      = elapsed_ms;
        end_ms = 0;
        found  = 1'b0;
        drive  = '0;
        n      = (cfg_len > MAX_NOTES_D) ? MAX_NOTES_D : int'(cfg_len);
        // first note whose cumulative end is not behind us
        for (int k = 0; k < n && !found; k++) begin
            end_ms += note_ms[k];
            if (t <= end_ms) begin
                found = 1'b1;
                if (note_ms[k] != 0 && end_ms - t > cfg_silence)
                    drive = note_freq[k];
            end
        end
        res.tone_freq    = drive;
        res.freq_changed = (drive != last_tone);
        res.tune_done    = !found;
        last_tone        = drive;
        if (!found && cfg_repeat && t > end_ms + cfg_repeat_gap)
            elapsed_ms = '0;
        return res;
    endfunction

    // result checking and prediction on accepted requests
    always @(posedge i_clk) begin
        tone_t got;
        tone_t want;
        if (i_rst_n) begin
            if (tone_if.valid && tone_if.ready) begin
                got = '{tone_if.tone_freq, tone_if.freq_changed, tone_if.tune_done};
                if (tone_expect_q.size() == 0) begin
                    $display("%0t: result with none pending, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = tone_expect_q.pop_front();
                    if (got.tone_freq !== want.tone_freq) begin
                        $display("%0t: tone_freq expected %0d got %0d",
                                 $time, want.tone_freq, got.tone_freq);
                        fail_count++;
                    end
                    if (got.freq_changed !== want.freq_changed) begin
                        $display("%0t: freq_changed expected %b got %b",
                                 $time, want.freq_changed, got.freq_changed);
                        fail_count++;
                    end
                    if (got.tune_done !== want.tune_done) begin
                        $display("%0t: tune_done expected %b got %b",
                                 $time, want.tune_done, got.tune_done);
                        fail_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready)
                tone_expect_q.push_back(play_request('{req_if.operation, req_if.entry_index,
                                                       req_if.entry_freq,
                                                       req_if.entry_duration}));
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_trig) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            tone_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            tone_if.ready <= 1'b0;
        end else begin
            tone_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(tone_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.operation      <= r.op;
        req_if.entry_index    <= r.slot;
        req_if.entry_freq     <= r.freq;
        req_if.entry_duration <= r.dur;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tone_expect_q.size() != 0)
            @(posedge i_clk);
        // walk may still be busy on nothing; let it settle
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] len, logic [CFG_DATA_W-1:0] rep,
                              logic [CFG_DATA_W-1:0] rgap, logic [CFG_DATA_W-1:0] sgap);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TUNE_LENGTH;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REPEAT_EN;
        i_cfg_data <= rep;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REPEAT_GAP;
        i_cfg_data <= rgap;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SILENCE_GAP;
        i_cfg_data <= sgap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_len        = len[LEN_W-1:0];
        cfg_repeat     = rep[0];
        cfg_repeat_gap = rgap[GAP_W-1:0];
        cfg_silence    = sgap[GAP_W-1:0];
    endtask

    task automatic random_items(int count);
        tone_req_t r;
        int        pick;
        repeat (count) begin
            pick   = $urandom_range(99);
            r.slot = $urandom_range(MAX_NOTES_D - 1);
            r.freq = ($urandom_range(7) == 0) ? '0 : FREQ_W'($urandom);
            r.dur  = DUR_W'($urandom);
            if (pick < 72) begin
                r.op = OP_TICK;
            end else if (pick < 88) begin
                r.op = OP_WRITE;
                // long notes only go to the last slot while it lies outside the tune
                if (r.slot == MAX_NOTES_D - 1 && cfg_len < MAX_NOTES_D
                        && $urandom_range(3) == 0) begin
                    if ($urandom_range(1) == 0)
                        r.dur = '1;
                end else begin
                    r.dur = ($urandom_range(4) == 0) ? '0 : DUR_W'($urandom_range(dur_cap, 1));
                end
            end else if (pick < 96) begin
                r.op = OP_RESTART;
            end else begin
                r.op = OP_SPARE;
            end
            send_request(r);
        end
    endtask

    task automatic shorten_last_note();
        send_request('{OP_WRITE, SLOT_W'(MAX_NOTES_D - 1), FREQ_W'($urandom), DUR_W'(2)});
    endtask

    task automatic test_table_load();
        for (int k = 0; k < MAX_NOTES_D; k++)
            send_request('{OP_WRITE, SLOT_W'(k), FREQ_W'(k * 16'h1111),
                           (k == MAX_NOTES_D - 1) ? DUR_W'(16'hFFFF) : DUR_W'(k % 4)});
    endtask

    task automatic test_operations();
        send_request('{OP_SPARE, '1, '1, '1});
        send_request('{OP_RESTART, '0, '0, '0});
        // default config: first note has no length, so the tune is already over
        send_request('{OP_TICK, '0, '0, '0});
        set_config(4, 0, 0, 0);
        repeat (7) send_request('{OP_TICK, SLOT_W'($urandom), FREQ_W'($urandom), '0});
        send_request('{OP_RESTART, '1, '0, '1});
        send_request('{OP_TICK, '0, '1, '0});
    endtask

    task automatic test_full_tune_repeat();
        shorten_last_note();
        set_config(16, 1, 0, 0);
        send_idle_pct = 45;
        dur_cap       = 2;
        random_items(90);
    endtask

    task automatic test_short_tune_no_repeat();
        set_config(4, 0, 0, 1);
        send_idle_pct = 0;
        stall_pct     = 0;
        dur_cap       = 6;
        random_items(100);
    endtask

    task automatic test_stalled_receiver();
        set_config(8, 1, 5, 2);
        send_idle_pct = 0;
        stall_pct     = 45;
        dur_cap       = 4;
        random_items(100);
    endtask

    task automatic test_gap_extremes();
        set_config(1, 1, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 10;
        stall_pct     = 10;
        dur_cap       = 8;
        random_items(60);
    endtask

    task automatic test_backpressure();
        set_config(6, 1, 2, 3);
        send_idle_pct = 0;
        stall_pct     = 0;
        dur_cap       = 4;
        hold_trig++;
        random_items(40);
        hold_trig++;
        random_items(40);
    endtask

    task automatic test_length_out_of_range();
        set_config(0, 1, 3, 0);
        send_idle_pct = 45;
        stall_pct     = 45;
        dur_cap       = 3;
        random_items(30);
        shorten_last_note();
        set_config(31, 1, 1, 0);
        send_idle_pct = 0;
        stall_pct     = 0;
        random_items(40);
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_TUNE_LENGTH;
        i_cfg_data            = '0;
        req_if.valid          = 1'b0;
        req_if.operation      = OP_WRITE;
        req_if.entry_index    = '0;
        req_if.entry_freq     = '0;
        req_if.entry_duration = '0;
        tone_if.ready         = 1'b0;
        elapsed_ms            = '0;
        last_tone             = '0;
        cfg_len               = TUNE_LEN_RST;
        cfg_repeat            = 1'b0;
        cfg_repeat_gap        = '0;
        cfg_silence           = SIL_GAP_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_table_load();
        test_operations();
        test_full_tune_repeat();
        test_short_tune_no_repeat();
        test_stalled_receiver();
        test_gap_extremes();
        test_backpressure();
        test_length_out_of_range();

        wait_drained();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
